>>> rtl/ntfs_rl_pkg.sv
`timescale 1ns / 1ps

package ntfs_rl_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned VCN_W  = 63;
  localparam int unsigned LCN_W  = 64;

  // Register index, taken from paddr[3] (registers sit 8 bytes apart)
  localparam logic REG_TARGET_VCN = 1'b0;

  localparam logic [LCN_W-1:0] LCN_ONES = {LCN_W{1'b1}};

  localparam logic [3:0] SIZE_MAX = 4'd8;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND      = 2'd0;
  localparam logic [1:0] STATUS_NOT_MAPPED = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;
  localparam logic [1:0] STATUS_MALFORMED  = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_DONE   = 2'd3
  } rl_phase_t;

  typedef struct packed {
    logic [7:0] run_byte;
    logic       last_byte;
  } rl_item_t;

  typedef struct packed {
    logic [LCN_W-1:0] mapped_lcn;
    logic [LCN_W-1:0] total_clusters;
    logic [1:0]       status;
  } rl_result_t;

  // Parser to top: whether the held byte produces a result, and that result
  typedef struct packed {
    logic       emit;
    rl_result_t result;
  } rl_emit_t;

endpackage

>>> rtl/ntfs_rl_cfg.sv
`timescale 1ns / 1ps

module ntfs_rl_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ntfs_rl_pkg::ADDR_W-1:0] paddr,
  input  logic [ntfs_rl_pkg::DATA_W-1:0] pwdata,
  output logic [ntfs_rl_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [ntfs_rl_pkg::VCN_W-1:0]  target_vcn
);
  import ntfs_rl_pkg::*;

  logic reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_vcn <= '0;
    end else if (wr_en && (reg_idx == REG_TARGET_VCN)) begin
      target_vcn <= pwdata[VCN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_TARGET_VCN) begin
      prdata = {{(DATA_W-VCN_W){1'b0}}, target_vcn};
    end
  end

endmodule

>>> rtl/ntfs_rl_parser.sv
`timescale 1ns / 1ps

module ntfs_rl_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  ntfs_rl_pkg::rl_item_t          item,
  input  logic [ntfs_rl_pkg::VCN_W-1:0] target_vcn,
  output ntfs_rl_pkg::rl_emit_t          emit_out
);
  import ntfs_rl_pkg::*;

  rl_phase_t        phase, phase_next;
  logic [3:0]       len_left, len_left_next;
  logic [3:0]       off_left, off_left_next;
  logic [3:0]       off_count, off_count_next;
  logic [2:0]       byte_pos, byte_pos_next;
  logic [LCN_W-1:0] run_len, run_len_next;
  logic [LCN_W-1:0] run_off, run_off_next;
  logic [LCN_W-1:0] cur_lcn, cur_lcn_next;
  logic [LCN_W-1:0] clus_pos, clus_pos_next;
  logic             found, found_next;
  logic [LCN_W-1:0] found_lcn, found_lcn_next;

  logic [7:0]       b;
  logic [3:0]       hdr_ls;
  logic [3:0]       hdr_os;
  logic [LCN_W-1:0] byte_shifted;
  logic [LCN_W-1:0] len_merge;
  logic [LCN_W-1:0] off_merge;
  logic [LCN_W-1:0] fin_len;
  logic [LCN_W-1:0] fin_off;
  logic [LCN_W-1:0] tgt;
  logic [LCN_W-1:0] vcn_diff;
  logic             hit;
  logic             finish;
  logic [1:0]       code;

  // Sign-extend an offset field of n bytes; eight bytes and zero bytes pass as is
  function automatic logic [LCN_W-1:0] sext_off(input logic [LCN_W-1:0] v,
                                                input logic [3:0] n);
    logic [LCN_W-1:0] r;
    r = v;
    case (n)
      4'd1: r = {{56{v[7]}},  v[7:0]};
      4'd2: r = {{48{v[15]}}, v[15:0]};
      4'd3: r = {{40{v[23]}}, v[23:0]};
      4'd4: r = {{32{v[31]}}, v[31:0]};
      4'd5: r = {{24{v[39]}}, v[39:0]};
      4'd6: r = {{16{v[47]}}, v[47:0]};
      4'd7: r = {{8{v[55]}},  v[55:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      len_left  <= '0;
      off_left  <= '0;
      off_count <= '0;
      byte_pos  <= '0;
      run_len   <= '0;
      run_off   <= '0;
      cur_lcn   <= '0;
      clus_pos  <= '0;
      found     <= 1'b0;
      found_lcn <= '0;
    end else if (step) begin
      phase     <= phase_next;
      len_left  <= len_left_next;
      off_left  <= off_left_next;
      off_count <= off_count_next;
      byte_pos  <= byte_pos_next;
      run_len   <= run_len_next;
      run_off   <= run_off_next;
      cur_lcn   <= cur_lcn_next;
      clus_pos  <= clus_pos_next;
      found     <= found_next;
      found_lcn <= found_lcn_next;
    end
  end

  assign b            = item.run_byte;
  assign hdr_ls       = b[3:0];
  assign hdr_os       = b[7:4];
  assign byte_shifted = {{(LCN_W-8){1'b0}}, b} << {byte_pos, 3'b000};
  assign len_merge    = run_len | byte_shifted;
  assign off_merge    = run_off | byte_shifted;
  assign fin_len      = (phase == PH_LENGTH) ? len_merge : run_len;
  assign fin_off      = sext_off((phase == PH_LENGTH) ? run_off : off_merge, off_count);
  assign tgt          = {{(LCN_W-VCN_W){1'b0}}, target_vcn};
  assign vcn_diff     = tgt - clus_pos;
  assign hit          = !found && (tgt >= clus_pos) && (vcn_diff < fin_len);

  always_comb begin
    phase_next     = phase;
    len_left_next  = len_left;
    off_left_next  = off_left;
    off_count_next = off_count;
    byte_pos_next  = byte_pos;
    run_len_next   = run_len;
    run_off_next   = run_off;
    cur_lcn_next   = cur_lcn;
    clus_pos_next  = clus_pos;
    found_next     = found;
    found_lcn_next = found_lcn;
    finish         = 1'b0;
    code           = STATUS_TRUNCATED;
    emit_out.emit  = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        if (b == 8'd0) begin
          emit_out.emit = 1'b1;
          code          = STATUS_NOT_MAPPED;
          phase_next    = PH_DONE;
        end else if ((hdr_ls > SIZE_MAX) || (hdr_os > SIZE_MAX)) begin
          emit_out.emit = 1'b1;
          code          = STATUS_MALFORMED;
          phase_next    = PH_DONE;
        end else begin
          len_left_next  = hdr_ls;
          off_left_next  = hdr_os;
          off_count_next = hdr_os;
          byte_pos_next  = '0;
          run_len_next   = '0;
          run_off_next   = '0;
          phase_next     = (hdr_ls != 4'd0) ? PH_LENGTH : PH_OFFSET;
          emit_out.emit  = item.last_byte;
          code           = STATUS_TRUNCATED;
        end
      end
      PH_LENGTH: begin
        run_len_next  = len_merge;
        byte_pos_next = byte_pos + 3'd1;
        len_left_next = (len_left != 4'd0) ? len_left - 4'd1 : len_left;
        if (len_left_next == 4'd0) begin
          byte_pos_next = '0;
          if (off_left != 4'd0) begin
            phase_next = PH_OFFSET;
          end else begin
            finish = 1'b1;
          end
        end
        emit_out.emit = item.last_byte;
      end
      PH_OFFSET: begin
        run_off_next  = off_merge;
        byte_pos_next = byte_pos + 3'd1;
        off_left_next = (off_left != 4'd0) ? off_left - 4'd1 : off_left;
        if (off_left_next == 4'd0) begin
          byte_pos_next = '0;
          finish        = 1'b1;
        end
        emit_out.emit = item.last_byte;
      end
      PH_DONE: begin
        emit_out.emit = 1'b0;
      end
      default: begin
        emit_out.emit = 1'b0;
      end
    endcase

    // Close the run: move the LCN, test the target, advance the VCN position
    if (finish) begin
      phase_next    = PH_HEADER;
      cur_lcn_next  = cur_lcn + fin_off;
      clus_pos_next = clus_pos + fin_len;
      code          = STATUS_NOT_MAPPED;
      if (hit) begin
        found_next     = 1'b1;
        found_lcn_next = cur_lcn + fin_off + vcn_diff;
      end
    end

    emit_out.result.total_clusters = clus_pos_next;
    emit_out.result.mapped_lcn     = found_next ? found_lcn_next : LCN_ONES;
    emit_out.result.status         = found_next ? STATUS_FOUND : code;

    // End of buffer: drop all list state
    if (item.last_byte) begin
      phase_next     = PH_HEADER;
      len_left_next  = '0;
      off_left_next  = '0;
      off_count_next = '0;
      byte_pos_next  = '0;
      run_len_next   = '0;
      run_off_next   = '0;
      cur_lcn_next   = '0;
      clus_pos_next  = '0;
      found_next     = 1'b0;
      found_lcn_next = '0;
    end
  end

endmodule

>>> rtl/ntfs_runlist_vcn_to_lcn_unit.sv
`timescale 1ns / 1ps

// Runlist decoder with a VCN-to-LCN lookup. Feed the bytes of an NTFS-style
// runlist one transaction at a time on the item channel; mark the final byte
// of the buffer with last_byte. Each run is a header byte (low nibble: length
// field size, high nibble: offset field size) followed by little-endian length
// and two's-complement offset fields. The unit tracks the running LCN and VCN
// position and records the LCN of target_vcn in the first run that covers it.
// One result transaction comes out per runlist, at a zero header, at a header
// with a size nibble over 8, or at the last byte: status 0 found (mapped_lcn
// valid), 1 not mapped, 2 truncated run, 3 malformed size; a match always
// reports found. total_clusters sums the complete runs. Bytes after a zero or
// malformed header are swallowed up to last_byte. Throughput is one byte per
// clock unless a result stall holds the input; an accepted byte goes into the
// input register, then the parse step loads the result register. The parse
// step is the only logic between the two registers: byte merge, offset sign
// extension and the 64-bit LCN add and target compare. target_vcn lives at
// APB address 0 (64-bit data, bits 62:0 used); write it only while the unit
// is drained.
module ntfs_runlist_vcn_to_lcn_unit (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ntfs_rl_pkg::ADDR_W-1:0] paddr,
  input  logic [ntfs_rl_pkg::DATA_W-1:0] pwdata,
  output logic [ntfs_rl_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  // Runlist byte stream
  input  logic                            item_valid,
  output logic                            item_stall,
  input  ntfs_rl_pkg::rl_item_t           item,
  // Lookup results
  output logic                            result_valid,
  input  logic                            result_stall,
  output ntfs_rl_pkg::rl_result_t         result
);
  import ntfs_rl_pkg::*;

  logic [VCN_W-1:0] target_vcn;
  rl_item_t         item_q;
  logic             item_q_valid;
  rl_emit_t         step_out;
  logic             advance;
  logic             accept;

  ntfs_rl_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .target_vcn (target_vcn)
  );

  ntfs_rl_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (item_q),
    .target_vcn (target_vcn),
    .emit_out   (step_out)
  );

  // Advance the held byte unless it produces a result while the result
  // register is full and stalled; bytes without a result always move on.
  assign advance    = item_q_valid && !(step_out.emit && result_valid && result_stall);
  assign item_stall = item_q_valid && !advance;
  assign accept     = item_valid && !item_stall;

  // Input register: load on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (accept) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  // Result register: hold while stalled, replace when a new result arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && step_out.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_out.emit) begin
      result <= step_out.result;
    end
  end

endmodule

>>> bench/ntfs_runlist_vcn_to_lcn_unit_tb.sv
`timescale 1ns / 1ps

module ntfs_runlist_vcn_to_lcn_unit_tb;
  import ntfs_rl_pkg::*;

  // Register byte addresses: registers sit 8 bytes apart, only index 0 exists
  localparam logic [ADDR_W-1:0] ADDR_TARGET_VCN = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_UNUSED     = 4'h8;

  localparam int PHASES         = 8;
  localparam int PHASE_BYTES    = 190;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 6;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                item_valid = 1'b0;
  logic                item_stall;
  rl_item_t            item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  rl_result_t          result;

  ntfs_runlist_vcn_to_lcn_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Byte transactions waiting to go out, and lookups waiting to come back
  rl_item_t    pending[$];
  rl_result_t  lookups_due[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned results_taken = 0;
  bit          failed = 1'b0;

  // Decoder mirror: configuration plus per-list parse state
  logic [VCN_W-1:0] target_vcn = '0;
  rl_phase_t        list_phase;
  logic [3:0]       len_left;
  logic [3:0]       off_left;
  logic [3:0]       off_size;
  logic [2:0]       field_pos;
  logic [LCN_W-1:0] run_len;
  logic [LCN_W-1:0] run_delta;
  logic [LCN_W-1:0] cur_lcn;
  logic [LCN_W-1:0] cur_vcn;
  logic             hit;
  logic [LCN_W-1:0] hit_lcn;

  task automatic clear_list();
    list_phase = PH_HEADER;
    len_left   = '0;
    off_left   = '0;
    off_size   = '0;
    field_pos  = '0;
    run_len    = '0;
    run_delta  = '0;
    cur_lcn    = '0;
    cur_vcn    = '0;
    hit        = 1'b0;
    hit_lcn    = '0;
  endtask

  // A match always reports found, whatever ended the list
  task automatic post_lookup(input logic [1:0] code);
    rl_result_t r;
    if (hit) begin
      r.mapped_lcn = hit_lcn;
      r.status     = STATUS_FOUND;
    end else begin
      r.mapped_lcn = LCN_ONES;
      r.status     = code;
    end
    r.total_clusters = cur_vcn;
    lookups_due.insert(lookups_due.size(), r);
  endtask

  // Apply the delta (sign-extended from its field size), test for the target,
  // then advance the VCN position past the run
  task automatic close_run();
    int               nbits;
    logic [LCN_W-1:0] delta;
    logic [LCN_W-1:0] tgt;
    nbits = 8 * off_size;
    delta = run_delta;
    tgt   = {1'b0, target_vcn};
    if (off_size > 0 && off_size < 8 && delta[nbits-1])
      delta = delta | (LCN_ONES << nbits);
    cur_lcn = cur_lcn + delta;
    if (!hit && tgt >= cur_vcn && (tgt - cur_vcn) < run_len) begin
      hit_lcn = cur_lcn + (tgt - cur_vcn);
      hit     = 1'b1;
    end
    cur_vcn    = cur_vcn + run_len;
    list_phase = PH_HEADER;
  endtask

  task automatic decode_byte(input rl_item_t it);
    logic [7:0] b;
    logic [3:0] len_sz;
    logic [3:0] off_sz;
    b      = it.run_byte;
    len_sz = b[3:0];
    off_sz = b[7:4];
    case (list_phase)
      PH_HEADER: begin
        if (b == 8'h00) begin
          post_lookup(STATUS_NOT_MAPPED);
          list_phase = PH_DONE;
        end else if (len_sz > SIZE_MAX || off_sz > SIZE_MAX) begin
          post_lookup(STATUS_MALFORMED);
          list_phase = PH_DONE;
        end else begin
          len_left   = len_sz;
          off_left   = off_sz;
          off_size   = off_sz;
          field_pos  = '0;
          run_len    = '0;
          run_delta  = '0;
          list_phase = (len_sz != 0) ? PH_LENGTH : PH_OFFSET;
          if (it.last_byte)
            post_lookup(STATUS_TRUNCATED);
        end
      end
      PH_LENGTH: begin
        run_len   = run_len | ({56'd0, b} << {field_pos, 3'b000});
        field_pos = field_pos + 3'd1;
        if (len_left > 0)
          len_left = len_left - 4'd1;
        if (len_left == 0) begin
          field_pos = '0;
          if (off_left > 0)
            list_phase = PH_OFFSET;
          else
            close_run();
        end
        if (it.last_byte)
          post_lookup(list_phase == PH_HEADER ? STATUS_NOT_MAPPED : STATUS_TRUNCATED);
      end
      PH_OFFSET: begin
        run_delta = run_delta | ({56'd0, b} << {field_pos, 3'b000});
        field_pos = field_pos + 3'd1;
        if (off_left > 0)
          off_left = off_left - 4'd1;
        if (off_left == 0) begin
          field_pos = '0;
          close_run();
        end
        if (it.last_byte)
          post_lookup(list_phase == PH_HEADER ? STATUS_NOT_MAPPED : STATUS_TRUNCATED);
      end
      default: ;
    endcase
    if (it.last_byte)
      clear_list();
  endtask

  // Sender: offer the next pending byte after a drawn number of idle cycles;
  // hold the payload while stalled; predict on every accepted transaction
  int unsigned tx_idle = 0;
  bit          tx_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      tx_idle = 0;
      clear_list();
    end else begin
      if (item_valid && !item_stall) begin
        decode_byte(item);
        bytes_taken++;
        tx_idle = tx_burst ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 31) == 0)
          tx_burst = !tx_burst;
      end
      if (!(item_valid && item_stall)) begin
        if (tx_idle > 0) begin
          tx_idle--;
          item_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          item       <= pending.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result against the oldest lookup, then
  // stall for a drawn number of cycles; twice hold off for a long stretch so
  // the unit backs up and stalls its byte input
  int unsigned rx_hold = 0;
  bit          rx_burst = 1'b0;
  rl_result_t  want;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_taken++;
        if (lookups_due.size() == 0) begin
          $display("%0t: unexpected result, lcn %h total %h status %0d", $time,
                   result.mapped_lcn, result.total_clusters, result.status);
          failed = 1'b1;
        end else begin
          want = lookups_due.pop_front();
          if (result.mapped_lcn !== want.mapped_lcn) begin
            $display("%0t: mapped_lcn expected %h actual %h", $time,
                     want.mapped_lcn, result.mapped_lcn);
            failed = 1'b1;
          end
          if (result.total_clusters !== want.total_clusters) begin
            $display("%0t: total_clusters expected %h actual %h", $time,
                     want.total_clusters, result.total_clusters);
            failed = 1'b1;
          end
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, result.status);
            failed = 1'b1;
          end
        end
        if (results_taken == 40 || results_taken == 120)
          rx_hold = LONG_HOLD;
        else
          rx_hold = rx_burst ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 15) == 0)
          rx_burst = !rx_burst;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      result_stall <= (rx_hold > 0);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic is_last);
    rl_item_t it;
    it.run_byte  = b;
    it.last_byte = is_last;
    pending.insert(pending.size(), it);
    bytes_queued++;
  endtask

  // Size nibble: mostly 0..2 so runs stay short and lookups hit, at times up to 8
  function automatic logic [3:0] pick_size();
    if ($urandom_range(0, 3) == 0)
      return 4'($urandom_range(0, 8));
    return 4'($urandom_range(0, 2));
  endfunction

  // Queue one runlist: mostly well-formed runs with random fields, ended by a
  // zero header, by the last run, by a cut mid-run or by a malformed header;
  // a few lists are plain noise
  task automatic add_runlist();
    logic [7:0]  bytes_q[$];
    logic [3:0]  len_sz;
    logic [3:0]  off_sz;
    logic [3:0]  nib;
    logic [7:0]  b;
    int unsigned style;
    int unsigned keep;
    style = $urandom_range(0, 99);
    if (style < 8) begin
      repeat ($urandom_range(1, 12)) begin
        b = 8'($urandom);
        bytes_q.insert(bytes_q.size(), b);
      end
    end else begin
      repeat ($urandom_range(1, 5)) begin
        len_sz = pick_size();
        off_sz = pick_size();
        if (len_sz == 0 && off_sz == 0)
          len_sz = 4'd1;
        bytes_q.insert(bytes_q.size(), {off_sz, len_sz});
        repeat (len_sz) begin
          b = 8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
          bytes_q.insert(bytes_q.size(), b);
        end
        repeat (off_sz) begin
          b = 8'($urandom);
          bytes_q.insert(bytes_q.size(), b);
        end
      end
      if (style < 22) begin
        // cut the list short
        keep = $urandom_range(1, bytes_q.size() - 1);
        while (bytes_q.size() > keep)
          void'(bytes_q.pop_back());
      end else if (style < 34) begin
        b   = 8'($urandom);
        nib = 4'($urandom_range(9, 15));
        if ($urandom_range(0, 1))
          b[3:0] = nib;
        else
          b[7:4] = nib;
        bytes_q.insert(bytes_q.size(), b);
        repeat ($urandom_range(0, 3)) begin
          b = 8'($urandom);
          bytes_q.insert(bytes_q.size(), b);
        end
      end else if (style < 70) begin
        bytes_q.insert(bytes_q.size(), 8'h00);
        repeat ($urandom_range(0, 3)) begin
          b = 8'($urandom);
          bytes_q.insert(bytes_q.size(), b);
        end
      end
    end
    foreach (bytes_q[i])
      queue_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the edge
  // where the access phase meets pready
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[3] == REG_TARGET_VCN)
      target_vcn = data[VCN_W-1:0];
  endtask

  // Wait until every byte is taken and every lookup has come back, then let
  // the pipeline settle in case the last bytes produce nothing
  task automatic wait_drained();
    do @(negedge clk); while (bytes_taken != bytes_queued || lookups_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] setting;
    int unsigned       phase_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed lists, target_vcn at its reset value of zero
    // negative one-byte delta, zero header, then an ignored trailing byte
    queue_byte(8'h11, 1'b0); queue_byte(8'h05, 1'b0); queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0); queue_byte(8'hAB, 1'b1);
    // length nibble over 8, rest swallowed
    queue_byte(8'h09, 1'b0); queue_byte(8'h00, 1'b1);
    // offset nibble over 8 on the last byte
    queue_byte(8'h90, 1'b1);
    // zero-length run, then a run with no offset field that still maps
    queue_byte(8'h01, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0); queue_byte(8'h07, 1'b1);
    // match, then cut off on a header: found still wins
    queue_byte(8'h11, 1'b0); queue_byte(8'h01, 1'b0); queue_byte(8'h10, 1'b0);
    queue_byte(8'h22, 1'b1);
    // header alone on the last byte
    queue_byte(8'h11, 1'b1);
    // eight-byte delta on a zero-length run
    queue_byte(8'h80, 1'b0);
    repeat (7) queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // zero header on the last byte
    queue_byte(8'h00, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = {DATA_W{1'b1}};               // top bit dropped: max VCN
        1: setting = 64'($urandom_range(0, 60));
        2: setting = '0;
        3: setting = {$urandom, $urandom};
        4: setting = 64'($urandom_range(0, 150));
        5: setting = 64'd1;
        6: setting = 64'($urandom_range(0, 100));
        default: setting = 64'($urandom_range(0, 300));
      endcase
      write_reg(ADDR_TARGET_VCN, setting);
      // no register at index 1: the write must leave target_vcn alone
      if (p == 2)
        write_reg(ADDR_UNUSED, {$urandom, $urandom});
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES)
        add_runlist();
      wait_drained();
    end

    if (failed || lookups_due.size() != 0)
      $display("simulation failed");
    else
      $display("simulation ok");
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
